/* design/kfa_pkg.sv */
// Shared constants, divider request/response types and saturation helpers
// for the keyframe animation sequencer. No dependencies.
`default_nettype none
package kfa_pkg;
  localparam int TIME_BITS  = 31;
  localparam int FRAME_BITS = 16;
  localparam int IDX_BITS   = 8;
  localparam int ANIM_COUNT = 256;
  localparam int LEAD_MS    = 200;
  localparam int LERP_BITS  = 17;
  localparam int LERP_ONE   = 65536;
  localparam int DW         = TIME_BITS + 1;
  localparam int CNT_BITS   = $clog2(DW + 1);
  localparam int FW         = TIME_BITS + 4;

  typedef struct packed {
    logic                start;
    logic [DW-1:0]       rem_init;
    logic [DW-1:0]       bits;
    logic [CNT_BITS-1:0] nq;
    logic [DW-1:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
    logic [DW-1:0] rem;
  } div_rsp_t;

  function automatic logic [TIME_BITS-1:0] time_sat(input logic [TIME_BITS:0] v);
    time_sat = v[TIME_BITS] ? {TIME_BITS{1'b1}} : v[TIME_BITS-1:0];
  endfunction

  function automatic logic [FRAME_BITS-1:0] frame_sat(input logic signed [FW-1:0] v);
    logic [FW-1:0] u;
    u = v;
    if (v < 0) begin
      frame_sat = '0;
    end else if (u[FW-1:FRAME_BITS] != '0) begin
      frame_sat = {FRAME_BITS{1'b1}};
    end else begin
      frame_sat = u[FRAME_BITS-1:0];
    end
  endfunction
endpackage
`default_nettype wire

/* design/kfa_div.sv */
// Bit-serial restoring divider shared by every division of the sequencer.
// Depends on kfa_pkg for the request and response types.
`default_nettype none
module kfa_div
  import kfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [DW-1:0]       rem;
  logic [DW-1:0]       bits;
  logic [DW-1:0]       divisor;
  logic [DW-1:0]       quot;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;
  logic [DW:0]         trial;
  logic [DW:0]         diff;

  // The remainder always stays below the divisor, so one extra bit covers the shift.
  assign trial = {rem, bits[DW-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == CNT_BITS'(1));
      if (req.start) begin
        busy    <= 1'b1;
        rem     <= req.rem_init;
        bits    <= req.bits;
        divisor <= req.divisor;
        quot    <= '0;
        cnt     <= req.nq;
      end else if (busy) begin
        if (!diff[DW]) begin
          rem  <= diff[DW-1:0];
          quot <= {quot[DW-2:0], 1'b1};
        end else begin
          rem  <= trial[DW-1:0];
          quot <= {quot[DW-2:0], 1'b0};
        end
        bits <= {bits[DW-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;
endmodule
`default_nettype wire

/* design/keyframe_animation_sequencer.sv */
// Keyframe animation sequencer: control sequencer and state around one shared divider.
// Depends on kfa_pkg and kfa_div.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | in_valid/in_stall  | op, now_time, anim_index ... play_reversed
//  output   | out_valid/out_stall| old_frame, cur_frame, back_lerp
//  config   | cfg_valid/cfg_ready| cfg_data (anim_enable)
//
// Without stalls, a clear or disabled step goes from the input transfer straight to the
// result; a step without a frame advance passes the check, clamp and blend states; with
// an advance it divides for the frame index, and once more for a loop wrap or a ping-pong
// fold. The serial divider (one quotient bit per cycle; 31 quotient bits for frame index
// and modulo, 17 for the blend factor) sets the length. Reset is synchronous; the block
// takes no new item until its result transfer has completed, and a stalled result holds.
`default_nettype none
module keyframe_animation_sequencer
  import kfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [TIME_BITS-1:0]  now_time,
  input  logic [IDX_BITS-1:0]   anim_index,
  input  logic                  anim_toggle,
  input  logic [15:0]           first_frame,
  input  logic [15:0]           frame_count,
  input  logic [15:0]           loop_count,
  input  logic [15:0]           frame_period,
  input  logic [15:0]           initial_delay,
  input  logic                  continuous,
  input  logic                  ping_pong,
  input  logic                  play_reversed,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FRAME_BITS-1:0] old_frame,
  output logic [FRAME_BITS-1:0] cur_frame,
  output logic [LERP_BITS-1:0]  back_lerp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_DIVF, S_FIX, S_MOD, S_FRM, S_PPM, S_ADV, S_CLMP, S_LRP, S_LDIV, S_OUT
  } state_t;

  state_t                 state;
  logic                   anim_enable;
  logic                   have_animation;
  logic [IDX_BITS:0]      anim_number;
  logic [TIME_BITS-1:0]   next_frame_time;
  logic [TIME_BITS-1:0]   prev_frame_time;
  logic [TIME_BITS-1:0]   anim_start_time;
  logic [FRAME_BITS-1:0]  frame_now;
  logic [FRAME_BITS-1:0]  frame_before;
  logic [LERP_BITS-1:0]   lerp_value;

  logic [TIME_BITS-1:0]   t;
  logic [15:0]            first, count, loop, period;
  logic                   pp, rev, neg;
  logic signed [FW-1:0]   f;

  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic                   accept;
  logic [IDX_BITS:0]      num_in;
  logic                   do_switch;
  logic                   div_go;
  logic [TIME_BITS-1:0]   start_sw;
  logic [TIME_BITS-1:0]   nt_cand;
  logic signed [FW-1:0]   diff;
  logic [FW-1:0]          mag;
  logic signed [FW-1:0]   span;
  logic signed [FW-1:0]   f_less;
  logic signed [FW-1:0]   first_s, count_s, loop_s;
  logic signed [FW-1:0]   quot_s, rem_s;
  logic [TIME_BITS-1:0]   passed;
  logic [LERP_BITS-1:0]   frac;

  kfa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cfg_ready = 1'b1;
  assign old_frame = frame_before;
  assign cur_frame = frame_now;
  assign back_lerp = lerp_value;

  always_comb begin
    num_in    = {anim_toggle, anim_index};
    do_switch = !have_animation ||
                ((num_in != anim_number) &&
                 !((anim_index == anim_number[IDX_BITS-1:0]) && continuous));
    start_sw  = time_sat({1'b0, next_frame_time} + (TIME_BITS+1)'(initial_delay));
    nt_cand   = (t < anim_start_time) ? anim_start_time
              : time_sat({1'b0, next_frame_time} + (TIME_BITS+1)'(period));
    diff      = $signed(FW'(nt_cand)) - $signed(FW'(anim_start_time));
    mag       = (diff < 0) ? FW'(-diff) : FW'(diff);
    first_s   = $signed(FW'(first));
    count_s   = $signed(FW'(count));
    loop_s    = $signed(FW'(loop));
    span      = pp ? (count_s <<< 1) : count_s;
    f_less    = f - span;
    quot_s    = $signed(FW'(div_rsp.quot));
    rem_s     = $signed(FW'(div_rsp.rem));
    passed    = t - prev_frame_time;
    frac      = (div_rsp.quot[LERP_BITS-1:0] > LERP_BITS'(LERP_ONE))
              ? LERP_BITS'(LERP_ONE) : div_rsp.quot[LERP_BITS-1:0];
    // States that hand a new division to the shared divider.
    div_go    = ((state == S_CHK) && (t >= next_frame_time) && (period != '0)) ||
                ((state == S_FIX) && (f >= span) && (loop != '0)) ||
                ((state == S_FRM) && !rev && pp && (f >= count_s) && (count != '0)) ||
                ((state == S_LRP) && (next_frame_time != prev_frame_time));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      anim_enable     <= 1'b1;
      have_animation  <= 1'b0;
      anim_number     <= '0;
      next_frame_time <= '0;
      prev_frame_time <= '0;
      anim_start_time <= '0;
      frame_now       <= '0;
      frame_before    <= '0;
      lerp_value      <= '0;
      div_req         <= '0;
    end else begin
      div_req.start <= div_go;
      if (cfg_valid && cfg_ready) begin
        anim_enable <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            t      <= now_time;
            first  <= first_frame;
            count  <= frame_count;
            loop   <= loop_count;
            period <= frame_period;
            pp     <= ping_pong;
            rev    <= play_reversed;
            if ((IDX_BITS+1)'(anim_index) >= (IDX_BITS+1)'(ANIM_COUNT)) begin
              state <= S_OUT;
            end else if (op) begin
              next_frame_time <= now_time;
              prev_frame_time <= now_time;
              anim_number     <= num_in;
              anim_start_time <= time_sat({1'b0, now_time} + (TIME_BITS+1)'(initial_delay));
              have_animation  <= 1'b1;
              frame_now       <= first_frame;
              frame_before    <= first_frame;
              state           <= S_OUT;
            end else if (!anim_enable) begin
              frame_now    <= '0;
              frame_before <= '0;
              lerp_value   <= '0;
              state        <= S_OUT;
            end else begin
              if (do_switch) begin
                anim_number     <= num_in;
                anim_start_time <= start_sw;
                have_animation  <= 1'b1;
              end
              state <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (t >= next_frame_time) begin
            frame_before    <= frame_now;
            prev_frame_time <= next_frame_time;
            if (period == '0) begin
              state <= S_OUT;
            end else begin
              next_frame_time  <= nt_cand;
              neg              <= (diff < 0);
              div_req.rem_init <= '0;
              div_req.bits     <= {mag[TIME_BITS-1:0], 1'b0};
              div_req.nq       <= CNT_BITS'(TIME_BITS);
              div_req.divisor  <= DW'(period);
              state            <= S_DIVF;
            end
          end else begin
            state <= S_CLMP;
          end
        end
        S_DIVF: begin
          if (div_rsp.done) begin
            f     <= neg ? -quot_s : quot_s;
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (f >= span) begin
            if (loop != '0) begin
              f                <= f_less;
              div_req.rem_init <= '0;
              div_req.bits     <= {f_less[TIME_BITS-1:0], 1'b0};
              div_req.nq       <= CNT_BITS'(TIME_BITS);
              div_req.divisor  <= DW'(loop);
              state            <= S_MOD;
            end else begin
              f               <= span - FW'(1);
              next_frame_time <= t;
              state           <= S_FRM;
            end
          end else begin
            state <= S_FRM;
          end
        end
        S_MOD: begin
          if (div_rsp.done) begin
            f     <= rem_s + count_s - loop_s;
            state <= S_FRM;
          end
        end
        S_FRM: begin
          if (rev) begin
            frame_now <= frame_sat(first_s + count_s - FW'(1) - f);
            state     <= S_ADV;
          end else if (pp && (f >= count_s) && (count != '0)) begin
            // Backward half of a ping-pong cycle needs the index modulo the frame count.
            div_req.rem_init <= '0;
            div_req.bits     <= {f[TIME_BITS-1:0], 1'b0};
            div_req.nq       <= CNT_BITS'(TIME_BITS);
            div_req.divisor  <= DW'(count);
            state            <= S_PPM;
          end else begin
            frame_now <= frame_sat(first_s + f);
            state     <= S_ADV;
          end
        end
        S_PPM: begin
          if (div_rsp.done) begin
            frame_now <= frame_sat(first_s + count_s - FW'(1) - rem_s);
            state     <= S_ADV;
          end
        end
        S_ADV: begin
          if (t > next_frame_time) begin
            next_frame_time <= t;
          end
          state <= S_CLMP;
        end
        S_CLMP: begin
          if ({1'b0, next_frame_time} > ({1'b0, t} + (TIME_BITS+1)'(LEAD_MS))) begin
            next_frame_time <= t;
          end
          if (prev_frame_time > t) begin
            prev_frame_time <= t;
          end
          state <= S_LRP;
        end
        S_LRP: begin
          if (next_frame_time == prev_frame_time) begin
            lerp_value <= '0;
            state      <= S_OUT;
          end else begin
            // Dividend is passed * 2^16: the top part seeds the remainder and the
            // last passed bit plus sixteen zeros are shifted in.
            div_req.rem_init <= DW'(passed >> 1);
            div_req.bits     <= {passed[0], {(DW-1){1'b0}}};
            div_req.nq       <= CNT_BITS'(LERP_BITS);
            div_req.divisor  <= DW'(next_frame_time - prev_frame_time);
            state            <= S_LDIV;
          end
        end
        S_LDIV: begin
          if (div_rsp.done) begin
            lerp_value <= LERP_BITS'(LERP_ONE) - frac;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while a result is pending");
  a_lerp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (back_lerp <= LERP_BITS'(LERP_ONE))) else $error("blend factor above one");
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !out_valid) else $error("divider started with result pending");
endmodule
`default_nettype wire
